// ===== sv/bagsw_pkg.sv =====
// shared constants, types and the gradient weight table for the blend/additive splitter
package bagsw_pkg;

  localparam int SAMPLES = 9;
  localparam int CH_W = 8;
  localparam int PROD_W = 16;
  localparam int GRAD_W = 32;
  localparam int FACTOR_W = 15;

  // c*a when both channel and alpha are 255
  localparam logic [PROD_W-1:0] FULL_PRODUCT = 16'd65025;
  localparam logic [FACTOR_W-1:0] LCM_NINE = 15'd2520;

  // 255*x/(3*65025*2520) reduces to x/1927800
  localparam int X_W = 35;
  localparam int XQ_W = 29;
  localparam logic [X_W-1:0] THREE_DENOM = 35'd491589000;
  localparam logic [20:0] DIV_D = 21'd1927800;
  localparam int RECIP_K = 50;
  localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_K) / 64'd1927800;
  localparam logic [29:0] RECIP_M = RECIP_FULL[29:0];
  localparam int MP_W = XQ_W + 30;
  localparam int REM_W = 22;

  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  // 9*2520/(j+1) for a sample that saturates at index j
  function automatic logic [FACTOR_W-1:0] grad_factor(input logic [3:0] j);
    logic [FACTOR_W-1:0] f;
    case (j)
      4'd0: f = 15'd22680;
      4'd1: f = 15'd11340;
      4'd2: f = 15'd7560;
      4'd3: f = 15'd5670;
      4'd4: f = 15'd4536;
      4'd5: f = 15'd3780;
      4'd6: f = 15'd3240;
      4'd7: f = 15'd2835;
      default: f = 15'd2520;
    endcase
    return f;
  endfunction

endpackage

// ===== sv/bagsw_chan.sv =====
// per colour channel: premultiply nine samples, then the registered gradient and additive colour
module bagsw_chan (
  input  logic                                           clk,
  input  bagsw_pkg::stage_en_t                           en,
  input  logic [bagsw_pkg::SAMPLES-1:0][bagsw_pkg::CH_W-1:0] chan,
  input  logic [bagsw_pkg::SAMPLES-1:0][bagsw_pkg::CH_W-1:0] alpha,
  output logic signed [bagsw_pkg::GRAD_W-1:0]            grad,
  output logic [bagsw_pkg::CH_W-1:0]                     add_color
);
  import bagsw_pkg::*;

  logic [SAMPLES-1:0][PROD_W-1:0] prod;
  logic signed [PROD_W:0]         diff;
  logic [FACTOR_W-1:0]            factor;
  logic [PROD_W-1:0]              add_sum;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      for (int j = 0; j < SAMPLES; j++) begin
        prod[j] <= PROD_W'(chan[j] * alpha[j]);
      end
    end
  end

  // walk down so the lowest saturated index wins
  always_comb begin
    diff = $signed({1'b0, prod[SAMPLES-1]}) - $signed({1'b0, prod[0]});
    factor = LCM_NINE;
    for (int j = SAMPLES - 1; j >= 0; j--) begin
      if (prod[j] == FULL_PRODUCT) begin
        diff = $signed({1'b0, FULL_PRODUCT}) - $signed({1'b0, prod[0]});
        factor = grad_factor(4'(j));
      end
    end
  end

  // floor(v/255) for v up to 65025, the sum stays below 65536
  assign add_sum = prod[0] + {8'd0, prod[0][PROD_W-1:8]} + 16'd1;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      grad <= GRAD_W'(diff * $signed({1'b0, factor}));
      add_color <= add_sum[PROD_W-1:8];
    end
  end

endmodule

// ===== sv/blend_add_split_from_gray_sweep_core.sv =====
// top level: blend alpha and additive colour from one pixel over nine gray backgrounds
//
//   channel  dir  width  contents
//   s_*      in   288    sample0..sample8, 32 bits each, RGBA with R lowest
//   m_*      out  32     blend_alpha, add_red, add_green, add_blue
//
// six register stages: products, gradients, sum and clamp flags, reciprocal
// multiply, remainder, quotient fix and output; one pixel per cycle sustained
// while m_tready is high. the stall chain frees each stage as soon as the
// next one moves, so bubbles fill while the output waits. rst clears only
// the valid bits; a stalled transaction holds in place.
module blend_add_split_from_gray_sweep_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,  // sample0, sample1, ... sample8
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata   // blend_alpha, add_red, add_green, add_blue
);
  import bagsw_pkg::*;

  localparam int STAGES = 6;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;

  logic [2:0][SAMPLES-1:0][CH_W-1:0] chan;
  logic [SAMPLES-1:0][CH_W-1:0]      alpha;
  logic signed [GRAD_W-1:0]          grad [3];
  logic [2:0][CH_W-1:0]              add2;
  stage_en_t                         chan_en;

  logic signed [X_W-1:0] grad_sum;
  logic signed [X_W-1:0] x_full;

  logic [XQ_W-1:0]      x3, x4;
  logic                 lo3, lo4, lo5, hi3, hi4, hi5;
  logic [2:0][CH_W-1:0] add3, add4, add5;
  logic [MP_W-1:0]      mp4;
  logic [8:0]           qe;
  logic [8:0]           qe5;
  logic [XQ_W-1:0]      qd;
  logic [XQ_W-1:0]      rem_full;
  logic [REM_W-1:0]     rem5;
  logic [8:0]           q_fix;
  logic [CH_W-1:0]      alpha_out;
  logic [31:0]          out_data;

  // stall chain
  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || m_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < SAMPLES; j++) begin
      for (int c = 0; c < 3; c++) begin
        chan[c][j] = s_tdata[32*j + 8*c +: CH_W];
      end
      alpha[j] = s_tdata[32*j + 24 +: CH_W];
    end
  end

  assign chan_en.s1 = en[0];
  assign chan_en.s2 = en[1];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    bagsw_chan u_chan (
      .clk       (clk),
      .en        (chan_en),
      .chan      (chan[c]),
      .alpha     (alpha),
      .grad      (grad[c]),
      .add_color (add2[c])
    );
  end

  // stage 3: 3*denominator minus the gradient sum, and clamp flags
  assign grad_sum = X_W'(grad[0]) + X_W'(grad[1]) + X_W'(grad[2]);
  assign x_full = $signed(THREE_DENOM) - grad_sum;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      x3 <= x_full[XQ_W-1:0];
      lo3 <= (x_full <= 0);
      hi3 <= (x_full >= $signed(THREE_DENOM));
      add3 <= add2;
    end
  end

  // stage 4: reciprocal multiply
  always_ff @(posedge clk) begin
    if (en[3]) begin
      mp4 <= MP_W'(x3 * RECIP_M);
      x4 <= x3;
      lo4 <= lo3;
      hi4 <= hi3;
      add4 <= add3;
    end
  end

  // stage 5: estimate is exact or one low, form the remainder
  assign qe = mp4[RECIP_K +: 9];
  assign qd = XQ_W'(qe * DIV_D);
  assign rem_full = x4 - qd;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      qe5 <= qe;
      rem5 <= rem_full[REM_W-1:0];
      lo5 <= lo4;
      hi5 <= hi4;
      add5 <= add4;
    end
  end

  // stage 6: correct and clamp
  assign q_fix = (rem5 >= REM_W'(DIV_D)) ? qe5 + 9'd1 : qe5;

  always_comb begin
    if (lo5) begin
      alpha_out = '0;
    end else if (hi5) begin
      alpha_out = 8'd255;
    end else begin
      alpha_out = q_fix[CH_W-1:0];
    end
  end

  assign out_data = {add5[2], add5[1], add5[0], alpha_out};

  always_ff @(posedge clk) begin
    if (en[5]) begin
      m_tdata <= out_data;
    end
  end

endmodule

// ===== tb/sv/blend_add_split_from_gray_sweep_core_test.sv =====
// testbench for the blend/additive splitter: queued pixel driver, checking monitor
module blend_add_split_from_gray_sweep_core_test;

  localparam longint FULL_PRODUCT = 65025;
  localparam longint LCM_1_TO_9 = 2520;
  localparam longint THREE_UNITS = 3 * FULL_PRODUCT * LCM_1_TO_9;
  localparam int RANDOM_PIXELS = 1000;
  localparam int CALM_TAIL = 200;

  typedef struct packed {
    logic [7:0] add_blue;
    logic [7:0] add_green;
    logic [7:0] add_red;
    logic [7:0] blend_alpha;
  } split_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [287:0] s_tdata = '0;  // sample0, sample1, ... sample8
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;       // blend_alpha, add_red, add_green, add_blue

  logic [287:0]  pending_pixels[$];
  split_result_t expected_splits[$];
  int            pixels_total = 0;
  int            pixels_sent = 0;
  int            mismatch_count = 0;
  int            send_gap = 0;
  int            recv_gap = 0;
  logic          idling_on = 1'b1;

  blend_add_split_from_gray_sweep_core u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #6 clk = ~clk;

  // exact split of one pixel, gradients in units of 1/(65025*2520)
  function automatic split_result_t split_pixel(input logic [287:0] px);
    longint        prod [9];
    longint        grad_sum;
    longint        num;
    longint        q;
    logic [31:0]   word;
    logic [7:0]    a0;
    bit            found;
    int            ch;
    int            k;
    split_result_t res;
    grad_sum = 0;
    for (ch = 0; ch < 3; ch++) begin
      for (k = 0; k < 9; k++) begin
        word = px[32*k +: 32];
        prod[k] = longint'(word[8*ch +: 8]) * longint'(word[31:24]);
      end
      found = 1'b0;
      for (k = 0; k < 9; k++) begin
        if (!found && prod[k] == FULL_PRODUCT) begin
          found = 1'b1;
          grad_sum += 9 * (prod[k] - prod[0]) * (LCM_1_TO_9 / (k + 1));
        end
      end
      if (!found)
        grad_sum += (prod[8] - prod[0]) * LCM_1_TO_9;
    end
    num = 255 * (THREE_UNITS - grad_sum);
    if (num <= 0) begin
      res.blend_alpha = 8'd0;
    end else begin
      q = num / THREE_UNITS;
      res.blend_alpha = (q > 255) ? 8'd255 : q[7:0];
    end
    a0 = px[31:24];
    res.add_red   = 8'((int'(px[7:0])   * int'(a0)) / 255);
    res.add_green = 8'((int'(px[15:8])  * int'(a0)) / 255);
    res.add_blue  = 8'((int'(px[23:16]) * int'(a0)) / 255);
    return res;
  endfunction

  // bytes lean toward 0 and 255 so channels saturate at many sample indexes
  function automatic logic [7:0] biased_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // pixel driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_splits.push_back(split_pixel(s_tdata));
        pixels_sent <= pixels_sent + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
          send_gap <= $urandom_range(0, 7);
          s_tvalid <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          s_tvalid <= 1'b1;
          s_tdata <= pending_pixels.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and backpressure
  always @(posedge clk) begin
    split_result_t got;
    split_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (expected_splits.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10)
            $display("unexpected transaction: %h", m_tdata);
        end else begin
          want = expected_splits.pop_front();
          if (got.blend_alpha !== want.blend_alpha || got.add_red !== want.add_red ||
              got.add_green !== want.add_green || got.add_blue !== want.add_blue) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("bad transaction: alpha %0d/%0d red %0d/%0d green %0d/%0d blue %0d/%0d",
                       want.blend_alpha, got.blend_alpha, want.add_red, got.add_red,
                       want.add_green, got.add_green, want.add_blue, got.add_blue);
          end
        end
      end
      if (recv_gap != 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
        recv_gap <= $urandom_range(0, 7);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    logic [287:0] px;
    int           n;
    int           k;
    int           b;

    px = '0;
    pending_pixels.push_back(px);
    pending_pixels.push_back({288{1'b1}});
    // first saturating sample at every index
    for (k = 0; k < 9; k++) begin
      px = '0;
      px[31:0] = 32'h80402010;
      px[32*k +: 32] = 32'hffffffff;
      if (k < 8)
        px[32*8 +: 32] = 32'h7f7f7f7f;
      pending_pixels.push_back(px);
    end
    // gradient sum far above three, alpha clamps low
    px = '0;
    px[32*1 +: 32] = 32'hffffffff;
    pending_pixels.push_back(px);
    // falling premultiplied values without saturation, alpha clamps high
    px = '0;
    px[31:0] = 32'hfffefefe;
    pending_pixels.push_back(px);
    // channels saturate at different samples, blue never
    px = '0;
    px[31:0] = 32'hff123456;
    px[32*2 +: 32] = 32'hff0000ff;
    px[32*5 +: 32] = 32'hff00ff00;
    px[32*8 +: 32] = 32'hff800000;
    pending_pixels.push_back(px);
    // transparent colours and opaque black
    px = {9{32'h00ffffff}};
    pending_pixels.push_back(px);
    px = {9{32'hff000000}};
    pending_pixels.push_back(px);
    // saturation of the first sample only in one channel
    px = {9{32'hfe7f7f7f}};
    px[31:0] = 32'hff0000ff;
    pending_pixels.push_back(px);

    for (n = 0; n < RANDOM_PIXELS; n++) begin
      if ($urandom_range(0, 9) < 3) begin
        for (k = 0; k < 9; k++)
          px[32*k +: 32] = $urandom;
      end else begin
        for (b = 0; b < 36; b++)
          px[8*b +: 8] = biased_byte();
      end
      pending_pixels.push_back(px);
    end
    pixels_total = pending_pixels.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (pixels_sent < pixels_total - CALM_TAIL)
      @(posedge clk);
    idling_on <= 1'b0;
    while (pixels_sent < pixels_total || expected_splits.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && expected_splits.size() == 0) begin
      $display("blend_add_split_from_gray_sweep_core: match");
    end else begin
      $display("blend_add_split_from_gray_sweep_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2400000;
    $display("blend_add_split_from_gray_sweep_core: mismatch");
    $finish;
  end

endmodule
